// File: src/frsc_pkg.sv
// ----------------------------------------------------------------------------
// frsc_pkg
// Shared types, constants and tables of the fan ramp and stall controller.
// ----------------------------------------------------------------------------
package frsc_pkg;

	localparam int DUTY_BITS     = 10;
	localparam int RPM_WINDOW_MS = 500;

	localparam int RPM_SCALE  = 30000 / RPM_WINDOW_MS;
	localparam int WIN_BITS   = $clog2(RPM_WINDOW_MS + 1);
	localparam int RPM_PROD_W = 16 + $clog2(RPM_SCALE + 1);

	localparam int SPEED_BITS = 7;
	localparam int MS_BITS    = 16;
	localparam int MES_BITS   = 6;
	localparam int PULSE_BITS = 4;
	localparam int REQ_BITS   = 8;
	localparam int TOTAL_BITS = 32;

	localparam logic [SPEED_BITS-1:0] SPEED_MAX = 7'd100;
	localparam logic [MES_BITS-1:0]   MES_MAX   = 6'd50;
	localparam logic [MS_BITS-1:0]    MS_SAT    = 16'hFFFF;

	// ramp progress: quotient below 100, so seven restoring steps
	localparam int DIV_STEPS    = 7;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
	localparam int DIV_W        = MS_BITS + DIV_STEPS;
	localparam int PCT_SCALE    = 100;

	// x / 100 for x below 2^14 as (x * 5243) >> 19
	localparam int PROD_BITS   = 14;
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_W     = PROD_BITS + 13;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_UP   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_DOWN = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STALL     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPEED = 2'd3;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_SPEED   = 2'd1;
	localparam logic [1:0] OP_UNBLOCK = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_UP      = 3'd1,
		MODE_RUN     = 3'd2,
		MODE_DOWN    = 3'd3,
		MODE_BLOCKED = 3'd4
	} fan_mode_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic mul;
		logic scale;
		logic finish;
		logic publish;
	} frsc_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic ramp_active;
	} frsc_sts_t;

	localparam int DUTY_STEPS = 1 << DUTY_BITS;
	localparam int DUTY_TOP   = DUTY_STEPS - 1;

	typedef logic [DUTY_BITS-1:0] duty_tbl_t [0:(1 << SPEED_BITS) - 1];

	function automatic duty_tbl_t build_duty_tbl();
		duty_tbl_t t;
		int        d;
		for (int i = 0; i < (1 << SPEED_BITS); i++) begin
			if (i == 0) begin
				d = 0;
			end else if (i >= 100) begin
				d = DUTY_TOP;
			end else begin
				d = (i * DUTY_STEPS + 50) / 100;
				if (d > DUTY_TOP) begin
					d = DUTY_TOP;
				end
			end
			t[i] = DUTY_BITS'(d);
		end
		return t;
	endfunction

	localparam duty_tbl_t DUTY_TBL = build_duty_tbl();

endpackage

// File: src/frsc_ctrl.sv
// ----------------------------------------------------------------------------
// frsc_ctrl
// Sequencer: accepts a beat, walks the ramp divider and scaler, hands off
// the result beat to the output register.
// ----------------------------------------------------------------------------
module frsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output frsc_pkg::frsc_cmd_t cmd,
	input  frsc_pkg::frsc_sts_t sts
);
	import frsc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EVAL  = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_SCALE = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

	state_t                  st_q, st_d;
	logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
	logic                    out_valid_q, out_valid_d;

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		st_d  = st_q;
		cnt_d = cnt_q;
		cmd   = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.is_tick && sts.ramp_active) begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					st_d          = ST_DIV;
				end else if (sts.is_tick) begin
					st_d = ST_FIN;
				end else begin
					st_d = ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					st_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				st_d    = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				st_d      = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				st_d       = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					st_d        = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.publish) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q        <= st_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q))
		else $error("state register lost one-hot encoding");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid)
		else $error("published beat not offered");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV && cnt_q != DIV_LAST) |=> st_q == ST_DIV)
		else $error("divider left before its last step");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && out_valid_q && !out_ready) |=> st_q == ST_DONE)
		else $error("result overwrote a beat still waiting");

endmodule

// File: src/frsc_datapath.sv
// ----------------------------------------------------------------------------
// frsc_datapath
// Fan state, config registers, RPM window, ramp divider and scaler, stall
// timer and the output register.
// ----------------------------------------------------------------------------
module frsc_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  frsc_pkg::frsc_cmd_t                   cmd,
	output frsc_pkg::frsc_sts_t                   sts,
	input  logic [1:0]                            operation,
	input  logic [frsc_pkg::REQ_BITS-1:0]         speed_request,
	input  logic [frsc_pkg::PULSE_BITS-1:0]       tach_pulses,
	input  logic                                  cfg_write,
	input  logic [frsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [frsc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output logic [frsc_pkg::DUTY_BITS-1:0]        pwm_duty,
	output logic [frsc_pkg::SPEED_BITS-1:0]       current_speed,
	output logic [2:0]                            fan_mode,
	output logic [15:0]                           measured_rpm,
	output logic                                  command_accepted,
	output logic [frsc_pkg::TOTAL_BITS-1:0]       tach_total
);
	import frsc_pkg::*;

	// config
	logic [MS_BITS-1:0]  ramp_up_q, ramp_down_q, stall_detect_q;
	logic [MES_BITS-1:0] min_speed_q;

	// fan state
	fan_mode_t             mode_q, mode_d;
	logic [SPEED_BITS-1:0] speed_q, speed_d;
	logic [SPEED_BITS-1:0] goal_q, goal_d;
	logic [SPEED_BITS-1:0] origin_q, origin_d;
	logic [MS_BITS-1:0]    elapsed_q, elapsed_d;
	logic                  armed_q, armed_d;
	logic [MS_BITS-1:0]    stall_q, stall_d;
	logic [WIN_BITS-1:0]   win_q, win_d;
	logic [15:0]           wpulse_q, wpulse_d;
	logic [15:0]           rpm_q, rpm_d;
	logic [TOTAL_BITS-1:0] total_q, total_d;
	logic                  acc_q, acc_d;
	logic                  tick_q;

	// ramp arithmetic
	logic [DIV_W-1:0]      rem_q, dvs_q;
	logic [DIV_STEPS-1:0]  quo_q;
	logic [PROD_BITS-1:0]  mul_q;
	logic                  neg_q;
	logic [SPEED_BITS-1:0] scale_q;

	logic [SPEED_BITS-1:0] req_sat;
	logic [16:0]           wp_sum;
	logic [15:0]           wp_sat;
	logic [WIN_BITS-1:0]   win_inc;
	logic [RPM_PROD_W-1:0] rpm_prod;
	logic [MS_BITS-1:0]    ramp_len;
	logic                  ramp_active;
	logic [MS_BITS-1:0]    stall_inc;
	logic [MES_BITS-1:0]   thr;
	logic [7:0]            delta;
	logic [SPEED_BITS-1:0] delta_mag;
	logic [SPEED_BITS-1:0] pct_left;
	logic [7:0]            g_sum;
	logic [SPEED_BITS-1:0] gs;
	logic [DIV_W-1:0]      rem_sub;
	logic [RECIP_W-1:0]    recip_prod;

	assign ramp_len    = (mode_q == MODE_UP) ? ramp_up_q : ramp_down_q;
	assign ramp_active = ((mode_q == MODE_UP) || (mode_q == MODE_DOWN)) &&
		(ramp_len != '0) && (elapsed_q < ramp_len);

	assign sts.is_tick     = tick_q;
	assign sts.ramp_active = ramp_active;

	assign req_sat  = (speed_request > REQ_BITS'(SPEED_MAX)) ? SPEED_MAX
		: speed_request[SPEED_BITS-1:0];
	assign wp_sum   = {1'b0, wpulse_q} + 17'(tach_pulses);
	assign wp_sat   = wp_sum[16] ? 16'hFFFF : wp_sum[15:0];
	assign win_inc  = win_q + 1'b1;
	assign rpm_prod = RPM_PROD_W'(wp_sat) * RPM_PROD_W'(RPM_SCALE);

	assign stall_inc = (stall_q == MS_SAT) ? stall_q : stall_q + 1'b1;
	assign thr       = (min_speed_q != '0) ? min_speed_q : MES_BITS'(1);

	assign delta     = {1'b0, goal_q} - {1'b0, origin_q};
	assign delta_mag = delta[7] ? SPEED_BITS'(-delta) : delta[SPEED_BITS-1:0];
	assign pct_left  = SPEED_MAX - quo_q;
	assign g_sum     = neg_q ? ({1'b0, origin_q} - {1'b0, scale_q})
		: ({1'b0, origin_q} + {1'b0, scale_q});
	assign rem_sub   = rem_q - dvs_q;
	assign recip_prod = RECIP_W'(mul_q) * RECIP_W'(RECIP_100);

	always_comb begin
		gs = g_sum[SPEED_BITS-1:0];
		if (min_speed_q != '0 && gs < SPEED_BITS'(min_speed_q) &&
			goal_q >= SPEED_BITS'(min_speed_q)) begin
			gs = SPEED_BITS'(min_speed_q);
		end
	end

	always_comb begin
		mode_d    = mode_q;
		speed_d   = speed_q;
		goal_d    = goal_q;
		origin_d  = origin_q;
		elapsed_d = elapsed_q;
		armed_d   = armed_q;
		stall_d   = stall_q;
		win_d     = win_q;
		wpulse_d  = wpulse_q;
		rpm_d     = rpm_q;
		total_d   = total_q;
		acc_d     = acc_q;
		if (cmd.load) begin
			total_d  = total_q + TOTAL_BITS'(tach_pulses);
			wpulse_d = wp_sat;
			acc_d    = 1'b1;
			case (operation)
				OP_TICK: begin
					win_d = win_inc;
					if (win_inc >= WIN_BITS'(RPM_WINDOW_MS)) begin
						rpm_d    = (rpm_prod > RPM_PROD_W'(16'hFFFF)) ? 16'hFFFF
							: rpm_prod[15:0];
						wpulse_d = '0;
						win_d    = '0;
					end
					if ((mode_q == MODE_UP || mode_q == MODE_DOWN) &&
						elapsed_q != MS_SAT) begin
						elapsed_d = elapsed_q + 1'b1;
					end
				end
				OP_SPEED: begin
					if (mode_q == MODE_BLOCKED && req_sat != '0) begin
						acc_d = 1'b0;
					end else begin
						goal_d = req_sat;
						if (req_sat == '0) begin
							if (speed_q != '0 && ramp_down_q != '0) begin
								mode_d    = MODE_DOWN;
								elapsed_d = '0;
								origin_d  = speed_q;
							end else begin
								speed_d = '0;
								goal_d  = '0;
								mode_d  = MODE_IDLE;
							end
						end else begin
							armed_d = 1'b0;
							stall_d = '0;
							if (speed_q != req_sat && ramp_up_q != '0) begin
								mode_d    = MODE_UP;
								elapsed_d = '0;
								origin_d  = speed_q;
							end else begin
								speed_d = req_sat;
								mode_d  = MODE_RUN;
							end
						end
					end
				end
				OP_UNBLOCK: begin
					if (mode_q == MODE_BLOCKED) begin
						mode_d  = MODE_IDLE;
						speed_d = '0;
						goal_d  = '0;
						armed_d = 1'b0;
						stall_d = '0;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.finish) begin
			if (mode_q == MODE_UP) begin
				if (ramp_active) begin
					speed_d = gs;
				end else begin
					speed_d = goal_q;
					mode_d  = MODE_RUN;
					armed_d = 1'b0;
					stall_d = '0;
				end
			end else if (mode_q == MODE_DOWN) begin
				if (ramp_active) begin
					speed_d = scale_q;
				end else begin
					speed_d = '0;
					mode_d  = MODE_IDLE;
				end
			end
			if (mode_d == MODE_RUN && speed_d >= SPEED_BITS'(thr)) begin
				if (rpm_q == '0) begin
					if (!armed_d) begin
						armed_d = 1'b1;
						stall_d = '0;
					end else begin
						stall_d = stall_inc;
						if (stall_d >= stall_detect_q) begin
							mode_d  = MODE_BLOCKED;
							speed_d = '0;
						end
					end
				end else begin
					armed_d = 1'b0;
					stall_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_up_q      <= 16'd1000;
			ramp_down_q    <= 16'd1000;
			stall_detect_q <= 16'd1500;
			min_speed_q    <= 6'd10;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RAMP_UP:   ramp_up_q      <= cfg_data;
				CFG_RAMP_DOWN: ramp_down_q    <= cfg_data;
				CFG_STALL:     stall_detect_q <= cfg_data;
				CFG_MIN_SPEED: min_speed_q    <= (cfg_data[MES_BITS-1:0] > MES_MAX) ? MES_MAX
					: cfg_data[MES_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			speed_q   <= '0;
			goal_q    <= '0;
			origin_q  <= '0;
			elapsed_q <= '0;
			armed_q   <= 1'b0;
			stall_q   <= '0;
			win_q     <= '0;
			wpulse_q  <= '0;
			rpm_q     <= '0;
			total_q   <= '0;
			acc_q     <= 1'b1;
			tick_q    <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			speed_q   <= speed_d;
			goal_q    <= goal_d;
			origin_q  <= origin_d;
			elapsed_q <= elapsed_d;
			armed_q   <= armed_d;
			stall_q   <= stall_d;
			win_q     <= win_d;
			wpulse_q  <= wpulse_d;
			rpm_q     <= rpm_d;
			total_q   <= total_d;
			acc_q     <= acc_d;
			if (cmd.load) begin
				tick_q <= (operation == OP_TICK);
			end
		end
	end

	// ramp progress divider, multiply and divide by one hundred
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= DIV_W'(elapsed_q) * DIV_W'(PCT_SCALE);
			dvs_q <= DIV_W'(ramp_len) << (DIV_STEPS - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
		if (cmd.mul) begin
			if (mode_q == MODE_UP) begin
				mul_q <= PROD_BITS'(delta_mag) * PROD_BITS'(quo_q);
				neg_q <= delta[7];
			end else begin
				mul_q <= PROD_BITS'(origin_q) * PROD_BITS'(pct_left);
				neg_q <= 1'b0;
			end
		end
		if (cmd.scale) begin
			scale_q <= SPEED_BITS'(recip_prod >> RECIP_SHIFT);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			pwm_duty         <= DUTY_TBL[speed_q];
			current_speed    <= speed_q;
			fan_mode         <= mode_q;
			measured_rpm     <= rpm_q;
			command_accepted <= acc_q;
			tach_total       <= total_q;
		end
	end

	a_blocked_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_BLOCKED |-> speed_q == '0)
		else $error("blocked fan still driven");

	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> speed_q == '0)
		else $error("idle fan still driven");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		speed_q <= SPEED_MAX)
		else $error("speed above full scale");

endmodule

// File: src/fan_ramp_stall_controller.sv
// ----------------------------------------------------------------------------
// fan_ramp_stall_controller
// PWM fan controller with linear soft start and stop, tach RPM window and
// stall detection.
// ----------------------------------------------------------------------------
// Flow: a command or block reset passes the evaluate and done states before it
// is offered; a tick outside a ramp passes evaluate, finish and done; a ramping
// tick also walks the seven-step restoring divider for ramp progress, then the
// multiply and scale states. One beat is in flight at a time, and the next beat
// is taken while a result waits in the output register.
// Reset: asynchronous, active low; state cleared, registers to their defaults.
module fan_ramp_stall_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            operation,
	input  logic [frsc_pkg::REQ_BITS-1:0]         speed_request,
	input  logic [frsc_pkg::PULSE_BITS-1:0]       tach_pulses,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [frsc_pkg::DUTY_BITS-1:0]        pwm_duty,
	output logic [frsc_pkg::SPEED_BITS-1:0]       current_speed,
	output logic [2:0]                            fan_mode,
	output logic [15:0]                           measured_rpm,
	output logic                                  command_accepted,
	output logic [frsc_pkg::TOTAL_BITS-1:0]       tach_total,
	input  logic                                  cfg_write,
	input  logic [frsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [frsc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import frsc_pkg::*;

	frsc_cmd_t cmd;
	frsc_sts_t sts;

	frsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	frsc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.operation        (operation),
		.speed_request    (speed_request),
		.tach_pulses      (tach_pulses),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.pwm_duty         (pwm_duty),
		.current_speed    (current_speed),
		.fan_mode         (fan_mode),
		.measured_rpm     (measured_rpm),
		.command_accepted (command_accepted),
		.tach_total       (tach_total)
	);

endmodule
